// File: src/mekd_pkg.sv
// ----------------------------------------------------------------------------
// mekd_pkg
// Shared types and constants for the mouse event keycode and drag detector.
// ----------------------------------------------------------------------------
package mekd_pkg;

  // event kinds
  localparam logic [3:0] FUNC_LDOWN  = 4'd0;
  localparam logic [3:0] FUNC_LUP    = 4'd1;
  localparam logic [3:0] FUNC_RDOWN  = 4'd2;
  localparam logic [3:0] FUNC_RUP    = 4'd3;
  localparam logic [3:0] FUNC_MDOWN  = 4'd4;
  localparam logic [3:0] FUNC_MUP    = 4'd5;
  localparam logic [3:0] FUNC_WHEEL  = 4'd6;
  localparam logic [3:0] FUNC_XDOWN  = 4'd7;
  localparam logic [3:0] FUNC_XUP    = 4'd8;
  localparam logic [3:0] FUNC_HWHEEL = 4'd9;
  localparam logic [3:0] FUNC_MOVE   = 4'd10;

  // pseudo key codes
  localparam logic [3:0] KEY_DRAG       = 4'd0;
  localparam logic [3:0] KEY_WHEEL_UP   = 4'd4;
  localparam logic [3:0] KEY_WHEEL_DN   = 4'd5;
  localparam logic [3:0] KEY_EXTRA1     = 4'd6;
  localparam logic [3:0] KEY_EXTRA2     = 4'd7;
  localparam logic [3:0] KEY_HWHEEL_RT  = 4'd8;
  localparam logic [3:0] KEY_HWHEEL_LT  = 4'd9;

  localparam logic [15:0] XBTN_1 = 16'd1;
  localparam logic [15:0] XBTN_2 = 16'd2;

  // register indexes
  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_MAP_EN    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  // result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [3:0] key_code;
    logic       release_res;
    logic       mouse_tag;
    logic       last;
  } result_t;

  typedef struct packed {
    logic button_held;
    logic drag_active;
  } status_t;

endpackage

// File: src/mouse_event_keycode_drag_detector_top.sv
// ----------------------------------------------------------------------------
// mouse_event_keycode_drag_detector_top
// Mouse event to pseudo key event translator with drag detection.
// ----------------------------------------------------------------------------
// One mouse event is taken per cycle into an input register unless that
// register is stalled; decode, the squared distance check and the state update
// happen while the event sits in the input register, and the zero, one or two
// resulting key transfers are written into a four-entry result queue, whose
// head is the output. The queue drains one result per cycle while m_tready is
// high: events that make one result flow at one per cycle, while wheel events
// and releases ending a drag make two. An event is held in the input register
// while the queue holds more than two results.
module mouse_event_keycode_drag_detector_top (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // wheel_negative, extra_button_id, pos_x, pos_y
  input  logic [4:0]  s_tuser,   // func, injected
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // key_code, release_res, mouse_tag
  output logic        m_tlast,
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        enable;
  logic        mouse_map_enable;
  logic [15:0] drag_threshold;
  logic        cfg_wr;

  logic               s1_valid;
  logic [3:0]         s1_func;
  logic               s1_injected;
  logic               s1_wneg;
  logic [15:0]        s1_xid;
  logic signed [15:0] s1_pos_x;
  logic signed [15:0] s1_pos_y;
  logic               s1_adv;

  logic [1:0]                    res_count;
  mekd_pkg::result_t             res0;
  mekd_pkg::result_t             res1;
  mekd_pkg::status_t             status;
  mekd_pkg::result_t             head;
  logic                          q_not_empty;
  logic [mekd_pkg::OQ_CNT_W-1:0] q_level;
  logic                          pop;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable           <= 1'b0;
      mouse_map_enable <= 1'b0;
      drag_threshold   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        mekd_pkg::REG_ENABLE:    enable           <= pwdata[0];
        mekd_pkg::REG_MAP_EN:    mouse_map_enable <= pwdata[0];
        mekd_pkg::REG_THRESHOLD: drag_threshold   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      mekd_pkg::REG_ENABLE:    prdata = {31'd0, enable};
      mekd_pkg::REG_MAP_EN:    prdata = {31'd0, mouse_map_enable};
      mekd_pkg::REG_THRESHOLD: prdata = {16'd0, drag_threshold};
      default:                 prdata = '0;
    endcase
  end

  // input register
  assign s1_adv   = s1_valid && (q_level <= mekd_pkg::OQ_CNT_W'(mekd_pkg::OQ_DEPTH - 2));
  assign s_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_func     <= s_tuser[3:0];
      s1_injected <= s_tuser[4];
      s1_wneg     <= s_tdata[0];
      s1_xid      <= s_tdata[16:1];
      s1_pos_x    <= s_tdata[32:17];
      s1_pos_y    <= s_tdata[48:33];
    end
  end

  mekd_core u_core (
    .clk              (clk),
    .rst              (rst),
    .fire             (s1_adv),
    .enable           (enable),
    .mouse_map_enable (mouse_map_enable),
    .drag_threshold   (drag_threshold),
    .func             (s1_func),
    .injected         (s1_injected),
    .wheel_negative   (s1_wneg),
    .extra_button_id  (s1_xid),
    .pos_x            (s1_pos_x),
    .pos_y            (s1_pos_y),
    .res_count        (res_count),
    .res0             (res0),
    .res1             (res1),
    .status           (status)
  );

  assign pop = m_tvalid && m_tready;

  mekd_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (s1_adv ? res_count : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .pop        (pop),
    .head       (head),
    .not_empty  (q_not_empty),
    .level      (q_level)
  );

  assign m_tvalid = q_not_empty;
  assign m_tdata  = {2'b00, head.mouse_tag, head.release_res, head.key_code};
  assign m_tlast  = head.last;

  // checks
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= mekd_pkg::OQ_CNT_W'(mekd_pkg::OQ_DEPTH))
    else $error("result queue overflow");

  a_pair_queued: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (q_level >= mekd_pkg::OQ_CNT_W'(2)))
    else $error("first result of a pair without its second");

  a_drag_held: assert property (@(posedge clk) disable iff (rst)
    status.drag_active |-> status.button_held)
    else $error("drag active without a held button");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_func) && $stable(s1_pos_x)))
    else $error("stalled event lost");

endmodule

// File: src/mekd_core.sv
// ----------------------------------------------------------------------------
// mekd_core
// Event decode, button and drag state, and squared distance check.
// ----------------------------------------------------------------------------
module mekd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic                  enable,
  input  logic                  mouse_map_enable,
  input  logic [15:0]           drag_threshold,
  input  logic [3:0]            func,
  input  logic                  injected,
  input  logic                  wheel_negative,
  input  logic [15:0]           extra_button_id,
  input  logic signed [15:0]    pos_x,
  input  logic signed [15:0]    pos_y,
  output logic [1:0]            res_count,
  output mekd_pkg::result_t     res0,
  output mekd_pkg::result_t     res1,
  output mekd_pkg::status_t     status
);

  logic               button_held;
  logic               drag_active;
  logic signed [15:0] anchor_x;
  logic signed [15:0] anchor_y;

  logic               button_held_next;
  logic               drag_active_next;
  logic               anchor_load;

  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [33:0] dx_sq;
  logic signed [33:0] dy_sq;
  logic [33:0]        dist_sq;
  logic [31:0]        thr_sq;
  logic               drag_hit;

  assign dx      = 17'(pos_x) - 17'(anchor_x);
  assign dy      = 17'(pos_y) - 17'(anchor_y);
  assign dx_sq   = 34'(dx) * 34'(dx);
  assign dy_sq   = 34'(dy) * 34'(dy);
  assign dist_sq = 34'(dx_sq) + 34'(dy_sq);
  assign thr_sq  = 32'(drag_threshold) * 32'(drag_threshold);
  assign drag_hit = button_held && !drag_active && (drag_threshold != 16'd0) &&
                    ({2'b00, thr_sq} < dist_sq);

  always_comb begin
    logic [3:0] code;
    logic       rel;
    logic       wheel;
    logic       btn;
    code             = mekd_pkg::KEY_DRAG;
    rel              = 1'b0;
    wheel            = 1'b0;
    btn              = 1'b0;
    res_count        = 2'd0;
    res0             = '0;
    res1             = '0;
    button_held_next = button_held;
    drag_active_next = drag_active;
    anchor_load      = 1'b0;

    if (!injected && enable && mouse_map_enable) begin
      unique case (func)
        mekd_pkg::FUNC_LDOWN, mekd_pkg::FUNC_LUP,
        mekd_pkg::FUNC_RDOWN, mekd_pkg::FUNC_RUP,
        mekd_pkg::FUNC_MDOWN, mekd_pkg::FUNC_MUP: begin
          code = {1'b0, func[3:1]} + 4'd1;
          rel  = func[0];
          btn  = 1'b1;
        end
        mekd_pkg::FUNC_WHEEL: begin
          code  = wheel_negative ? mekd_pkg::KEY_WHEEL_DN : mekd_pkg::KEY_WHEEL_UP;
          wheel = 1'b1;
        end
        mekd_pkg::FUNC_HWHEEL: begin
          code  = wheel_negative ? mekd_pkg::KEY_HWHEEL_LT : mekd_pkg::KEY_HWHEEL_RT;
          wheel = 1'b1;
        end
        mekd_pkg::FUNC_XDOWN, mekd_pkg::FUNC_XUP: begin
          rel = (func == mekd_pkg::FUNC_XUP);
          if (extra_button_id == mekd_pkg::XBTN_1) begin
            code = mekd_pkg::KEY_EXTRA1;
            btn  = 1'b1;
          end else if (extra_button_id == mekd_pkg::XBTN_2) begin
            code = mekd_pkg::KEY_EXTRA2;
            btn  = 1'b1;
          end
        end
        mekd_pkg::FUNC_MOVE: begin
          if (drag_hit) begin
            res_count        = 2'd1;
            res0             = '{key_code: mekd_pkg::KEY_DRAG, release_res: 1'b0,
                                 mouse_tag: 1'b1, last: 1'b1};
            drag_active_next = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (wheel) begin
        res_count = 2'd2;
        res0 = '{key_code: code, release_res: 1'b0, mouse_tag: 1'b1, last: 1'b0};
        res1 = '{key_code: code, release_res: 1'b1, mouse_tag: 1'b0, last: 1'b1};
      end else if (btn && rel) begin
        button_held_next = 1'b0;
        if (drag_active) begin
          drag_active_next = 1'b0;
          res_count = 2'd2;
          res0 = '{key_code: mekd_pkg::KEY_DRAG, release_res: 1'b1,
                   mouse_tag: 1'b0, last: 1'b0};
          res1 = '{key_code: code, release_res: 1'b1, mouse_tag: 1'b1, last: 1'b1};
        end else begin
          res_count = 2'd1;
          res0 = '{key_code: code, release_res: 1'b1, mouse_tag: 1'b1, last: 1'b1};
        end
      end else if (btn) begin
        button_held_next = 1'b1;
        anchor_load      = 1'b1;
        res_count = 2'd1;
        res0 = '{key_code: code, release_res: 1'b0, mouse_tag: 1'b1, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_held <= 1'b0;
      drag_active <= 1'b0;
      anchor_x    <= '0;
      anchor_y    <= '0;
    end else if (fire) begin
      button_held <= button_held_next;
      drag_active <= drag_active_next;
      if (anchor_load) begin
        anchor_x <= pos_x;
        anchor_y <= pos_y;
      end
    end
  end

  assign status = '{button_held: button_held, drag_active: drag_active};

endmodule

// File: src/mekd_outq.sv
// ----------------------------------------------------------------------------
// mekd_outq
// Small result queue; takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module mekd_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    push_count,
  input  mekd_pkg::result_t             push0,
  input  mekd_pkg::result_t             push1,
  input  logic                          pop,
  output mekd_pkg::result_t             head,
  output logic                          not_empty,
  output logic [mekd_pkg::OQ_CNT_W-1:0] level
);

  mekd_pkg::result_t                   mem [mekd_pkg::OQ_DEPTH];
  logic [mekd_pkg::OQ_PTR_W-1:0]       wr_ptr;
  logic [mekd_pkg::OQ_PTR_W-1:0]       rd_ptr;
  logic [mekd_pkg::OQ_CNT_W-1:0]       count;
  logic [mekd_pkg::OQ_PTR_W-1:0]       wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + mekd_pkg::OQ_PTR_W'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + mekd_pkg::OQ_CNT_W'(push_count) -
               mekd_pkg::OQ_CNT_W'(pop);
    end
  end

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign level     = count;

endmodule

// File: sim/key_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_event_checker
// Watches the event, key and register channels of the drag detector, predicts
// the pseudo key transfers of every accepted mouse event from its own copy of
// the button, drag and anchor state, and compares each key transfer in order.
// ----------------------------------------------------------------------------
module key_event_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,   // wheel_negative, extra_button_id, pos_x, pos_y
  input  logic [4:0]  s_tuser,   // func, injected
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // key_code, release_res, mouse_tag
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  localparam logic [3:0] KEY_LEFT   = 4'd1;
  localparam logic [3:0] KEY_RIGHT  = 4'd2;
  localparam logic [3:0] KEY_MIDDLE = 4'd3;

  logic               en, map_en;
  logic [15:0]        thr;
  logic               held, dragging;
  logic signed [15:0] anc_x, anc_y;
  mekd_pkg::result_t  keys_due[$];

  function automatic mekd_pkg::result_t key(logic [3:0] code, logic rel, logic tag);
    mekd_pkg::result_t r;
    r.key_code    = code;
    r.release_res = rel;
    r.mouse_tag   = tag;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic void predict_keys(logic [3:0] fn, logic inj, logic wneg,
                                       logic [15:0] xid,
                                       logic signed [15:0] px, logic signed [15:0] py);
    logic [3:0]        code;
    bit                rel, wheel, ok;
    longint            dx, dy;
    longint unsigned   dist2, thr2;
    mekd_pkg::result_t burst[$];
    if (inj || !en || !map_en) return;
    ok = 1;
    rel = 0;
    wheel = 0;
    code = mekd_pkg::KEY_DRAG;
    case (fn)
      mekd_pkg::FUNC_LDOWN:  code = KEY_LEFT;
      mekd_pkg::FUNC_LUP: begin
        code = KEY_LEFT;
        rel = 1;
      end
      mekd_pkg::FUNC_RDOWN:  code = KEY_RIGHT;
      mekd_pkg::FUNC_RUP: begin
        code = KEY_RIGHT;
        rel = 1;
      end
      mekd_pkg::FUNC_MDOWN:  code = KEY_MIDDLE;
      mekd_pkg::FUNC_MUP: begin
        code = KEY_MIDDLE;
        rel = 1;
      end
      mekd_pkg::FUNC_WHEEL: begin
        code = wneg ? mekd_pkg::KEY_WHEEL_DN : mekd_pkg::KEY_WHEEL_UP;
        wheel = 1;
      end
      mekd_pkg::FUNC_XDOWN, mekd_pkg::FUNC_XUP: begin
        if (xid == mekd_pkg::XBTN_1) code = mekd_pkg::KEY_EXTRA1;
        else if (xid == mekd_pkg::XBTN_2) code = mekd_pkg::KEY_EXTRA2;
        else ok = 0;
        rel = (fn == mekd_pkg::FUNC_XUP);
      end
      mekd_pkg::FUNC_HWHEEL: begin
        code = wneg ? mekd_pkg::KEY_HWHEEL_LT : mekd_pkg::KEY_HWHEEL_RT;
        wheel = 1;
      end
      mekd_pkg::FUNC_MOVE: begin
        ok = 0;
        dx = longint'(px) - longint'(anc_x);
        dy = longint'(py) - longint'(anc_y);
        dist2 = longint'(dx * dx + dy * dy);
        thr2 = longint'(thr) * longint'(thr);
        if (held && !dragging && thr != 0 && thr2 < dist2) begin
          dragging = 1;
          burst = {burst, key(mekd_pkg::KEY_DRAG, 1'b0, 1'b1)};
        end
      end
      default: ok = 0;
    endcase
    if (ok) begin
      if (rel) begin
        held = 0;
        if (dragging) begin
          dragging = 0;
          burst = {burst, key(mekd_pkg::KEY_DRAG, 1'b1, 1'b0)};
        end
      end else if (!wheel) begin
        held = 1;
        anc_x = px;
        anc_y = py;
      end
      burst = {burst, key(code, rel, 1'b1)};
      if (wheel) burst = {burst, key(code, 1'b1, 1'b0)};
    end
    if (burst.size() == 0) return;
    burst[burst.size() - 1].last = 1'b1;
    keys_due = {keys_due, burst};
  endfunction

  always @(posedge clk) begin
    mekd_pkg::result_t want;
    if (rst) begin
      en = 0;
      map_en = 0;
      thr = '0;
      held = 0;
      dragging = 0;
      anc_x = '0;
      anc_y = '0;
      keys_due.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          mekd_pkg::REG_ENABLE:    en = pwdata[0];
          mekd_pkg::REG_MAP_EN:    map_en = pwdata[0];
          mekd_pkg::REG_THRESHOLD: thr = pwdata[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        predict_keys(s_tuser[3:0], s_tuser[4], s_tdata[0], s_tdata[16:1],
                     s_tdata[32:17], s_tdata[48:33]);
      if (m_tvalid && m_tready) begin
        if (keys_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: key transfer with none expected: code %0d rel %0b tag %0b %s%0b",
                     $realtime, m_tdata[3:0], m_tdata[4], m_tdata[5], "last ", m_tlast);
        end else begin
          want = keys_due.pop_front();
          if (m_tdata[3:0] !== want.key_code || m_tdata[4] !== want.release_res ||
              m_tdata[5] !== want.mouse_tag || m_tlast !== want.last) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: key mismatch: exp code %0d rel %0b tag %0b last %0b, ",
                        "got code %0d rel %0b tag %0b last %0b"},
                       $realtime, want.key_code, want.release_res, want.mouse_tag,
                       want.last, m_tdata[3:0], m_tdata[4], m_tdata[5], m_tlast);
          end
        end
      end
    end
    pending = keys_due.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives mouse events and register writes into the drag detector: a directed
// pass over every event kind, the drag threshold edges and the drop cases,
// then phases of random press-move-release gestures mixed with noise, under
// random idle gaps on both streams. key_event_checker does the comparing.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [3:0] FUNC_OTHER = 4'd11;
  localparam logic [3:0] FUNC_TOP   = 4'd15;

  logic        clk;
  logic        rst;
  logic        s_tvalid, s_tready;
  logic [55:0] s_tdata;    // wheel_negative, extra_button_id, pos_x, pos_y
  logic [4:0]  s_tuser;    // func, injected
  logic        m_tvalid, m_tready;
  logic [7:0]  m_tdata;    // key_code, release_res, mouse_tag
  logic        m_tlast;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          errors, pending;

  bit                 tx_calm, rx_calm, out_fire;
  int                 rx_stall;
  logic [15:0]        cur_thr;
  bit                 cur_live;
  logic signed [15:0] gen_ax, gen_ay;
  int                 live_items;

  mouse_event_keycode_drag_detector_top u_dut (.*);

  key_event_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // key side: a random stall, possibly none, after every transfer
  always @(posedge clk) out_fire <= m_tvalid && m_tready;

  initial begin
    m_tready = 0;
    rx_stall = 0;
    rx_calm = 0;
    forever begin
      @(negedge clk);
      if (out_fire) begin
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
        rx_stall = rx_calm ? 0 : $urandom_range(0, 17);
      end
      if (rst) m_tready = 0;
      else if (rx_stall > 0) begin
        m_tready = 0;
        rx_stall--;
      end else m_tready = 1;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel = 1;
    penable = 0;
    pwrite = 1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  task automatic drain();
    s_tvalid = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_regs(bit en, bit map_en, logic [15:0] thr);
    drain();
    reg_write(mekd_pkg::REG_ENABLE, {31'd0, en});
    reg_write(mekd_pkg::REG_MAP_EN, {31'd0, map_en});
    reg_write(mekd_pkg::REG_THRESHOLD, {16'd0, thr});
    cur_thr = thr;
    cur_live = en && map_en;
  endtask

  task automatic send_event(logic [3:0] fn, bit inj, bit wneg, logic [15:0] xid,
                            logic signed [15:0] px, logic signed [15:0] py);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = {7'd0, py, px, xid, wneg};
    s_tuser = {inj, fn};
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (cur_live && !inj) live_items++;
  endtask

  function automatic logic signed [15:0] near(logic signed [15:0] base);
    int scale;
    scale = (cur_thr == 0) ? 50 : int'(cur_thr);
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'(base + $urandom_range(0, 2 * scale + 2) - (scale + 1));
  endfunction

  task automatic noise_event();
    send_event(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic gesture();
    logic [3:0]  dn, up;
    logic [15:0] xid;
    int          moves;
    case ($urandom_range(0, 3))
      0: begin dn = mekd_pkg::FUNC_LDOWN; up = mekd_pkg::FUNC_LUP; end
      1: begin dn = mekd_pkg::FUNC_RDOWN; up = mekd_pkg::FUNC_RUP; end
      2: begin dn = mekd_pkg::FUNC_MDOWN; up = mekd_pkg::FUNC_MUP; end
      default: begin dn = mekd_pkg::FUNC_XDOWN; up = mekd_pkg::FUNC_XUP; end
    endcase
    xid = $urandom_range(0, 1) ? mekd_pkg::XBTN_1 : mekd_pkg::XBTN_2;
    gen_ax = 16'($urandom);
    gen_ay = 16'($urandom);
    send_event(dn, $urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)), xid,
               gen_ax, gen_ay);
    moves = $urandom_range(0, 5);
    repeat (moves) begin
      if ($urandom_range(0, 9) == 0)
        send_event($urandom_range(0, 1) ? mekd_pkg::FUNC_WHEEL : mekd_pkg::FUNC_HWHEEL,
                   1'b0, 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                   16'($urandom));
      else
        send_event(mekd_pkg::FUNC_MOVE, $urandom_range(0, 15) == 0,
                   1'($urandom_range(0, 1)), 16'($urandom),
                   near(gen_ax), near(gen_ay));
    end
    send_event(up, $urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)), xid,
               16'($urandom), 16'($urandom));
  endtask

  initial begin
    int          phase_items;
    logic [15:0] thr;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    tx_calm = 0;
    cur_thr = '0;
    cur_live = 0;
    live_items = 0;
    repeat (11) @(negedge clk);
    rst = 0;

    // directed: threshold 10, drag only when strictly beyond it
    set_regs(1'b1, 1'b1, 16'd10);
    send_event(mekd_pkg::FUNC_LDOWN, 1'b0, 1'b0, 16'd0, 16'sd0, 16'sd0);
    send_event(mekd_pkg::FUNC_MOVE, 1'b0, 1'b0, 16'd0, 16'sd3, 16'sd4);
    send_event(mekd_pkg::FUNC_MOVE, 1'b0, 1'b0, 16'd0, 16'sd6, 16'sd8);
    send_event(mekd_pkg::FUNC_MOVE, 1'b0, 1'b0, 16'd0, 16'sd7, 16'sd8);
    send_event(mekd_pkg::FUNC_MOVE, 1'b0, 1'b0, 16'd0, -16'sd100, -16'sd100);
    send_event(mekd_pkg::FUNC_LUP, 1'b0, 1'b0, 16'd0, 16'sd0, 16'sd0);
    send_event(mekd_pkg::FUNC_MOVE, 1'b0, 1'b0, 16'd0, 16'sd50, 16'sd50);
    send_event(mekd_pkg::FUNC_RDOWN, 1'b0, 1'b0, 16'd0, -16'sd5, -16'sd5);
    send_event(mekd_pkg::FUNC_RUP, 1'b0, 1'b0, 16'd0, 16'sd0, 16'sd0);
    send_event(mekd_pkg::FUNC_MDOWN, 1'b0, 1'b0, 16'd0, 16'sd32767, 16'sd32767);
    send_event(mekd_pkg::FUNC_MUP, 1'b0, 1'b0, 16'd0, 16'sd0, 16'sd0);
    send_event(mekd_pkg::FUNC_WHEEL, 1'b0, 1'b0, 16'd0, 16'sd0, 16'sd0);
    send_event(mekd_pkg::FUNC_WHEEL, 1'b0, 1'b1, 16'd0, 16'sd0, 16'sd0);
    send_event(mekd_pkg::FUNC_HWHEEL, 1'b0, 1'b0, 16'd0, 16'sd0, 16'sd0);
    send_event(mekd_pkg::FUNC_HWHEEL, 1'b0, 1'b1, 16'd0, 16'sd0, 16'sd0);
    send_event(mekd_pkg::FUNC_XDOWN, 1'b0, 1'b0, mekd_pkg::XBTN_1, 16'sd1, 16'sd1);
    send_event(mekd_pkg::FUNC_XUP, 1'b0, 1'b0, mekd_pkg::XBTN_2, 16'sd1, 16'sd1);
    send_event(mekd_pkg::FUNC_XDOWN, 1'b0, 1'b0, 16'd0, 16'sd1, 16'sd1);
    send_event(mekd_pkg::FUNC_XDOWN, 1'b0, 1'b0, 16'hFFFF, 16'sd1, 16'sd1);
    send_event(mekd_pkg::FUNC_LDOWN, 1'b1, 1'b0, 16'd0, 16'sd9, 16'sd9);
    send_event(FUNC_OTHER, 1'b0, 1'b0, 16'd0, 16'sd0, 16'sd0);
    send_event(FUNC_TOP, 1'b0, 1'b1, 16'hFFFF, -16'sd1, -16'sd1);

    // widest threshold against the widest distance, then threshold zero and the disabled cases
    set_regs(1'b1, 1'b1, 16'hFFFF);
    send_event(mekd_pkg::FUNC_LDOWN, 1'b0, 1'b0, 16'd0, -16'sd32768, -16'sd32768);
    send_event(mekd_pkg::FUNC_MOVE, 1'b0, 1'b0, 16'd0, 16'sd32767, 16'sd32767);
    send_event(mekd_pkg::FUNC_LUP, 1'b0, 1'b0, 16'd0, 16'sd0, 16'sd0);
    set_regs(1'b1, 1'b1, 16'd0);
    send_event(mekd_pkg::FUNC_LDOWN, 1'b0, 1'b0, 16'd0, -16'sd32768, 16'sd32767);
    send_event(mekd_pkg::FUNC_MOVE, 1'b0, 1'b0, 16'd0, 16'sd32767, -16'sd32768);
    send_event(mekd_pkg::FUNC_LUP, 1'b0, 1'b0, 16'd0, 16'sd0, 16'sd0);
    set_regs(1'b0, 1'b1, 16'd1);
    send_event(mekd_pkg::FUNC_WHEEL, 1'b0, 1'b0, 16'd0, 16'sd0, 16'sd0);
    set_regs(1'b1, 1'b0, 16'd1);
    send_event(mekd_pkg::FUNC_WHEEL, 1'b0, 1'b0, 16'd0, 16'sd0, 16'sd0);

    live_items = 0;
    while (live_items < 1500) begin
      case ($urandom_range(0, 5))
        0: thr = 16'd0;
        1: thr = 16'd1;
        2: thr = 16'hFFFF;
        3: thr = 16'($urandom);
        default: thr = 16'($urandom_range(2, 40));
      endcase
      case ($urandom_range(0, 7))
        0: set_regs(1'b0, 1'($urandom_range(0, 1)), thr);
        1: set_regs(1'b1, 1'b0, thr);
        default: set_regs(1'b1, 1'b1, thr);
      endcase
      tx_calm = ($urandom_range(0, 3) == 0);
      phase_items = cur_live ? 150 : 20;
      for (int i = 0; i < phase_items; ) begin
        if (i >= phase_items / 2 && i < phase_items / 2 + 3) drain();
        if ($urandom_range(0, 9) < 7) begin
          gesture();
          i += 4;
        end else begin
          noise_event();
          i++;
        end
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
